@@ design/utf8_to_utf16_ucs4_decoder_defines.svh @@
// Assertion macros used by the UTF-8 decoder top level.
`ifndef UTF8_TO_UTF16_UCS4_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_UCS4_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define U8DEC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8dec assertion failed");

// Next-cycle implication, disabled while in reset.
`define U8DEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8dec assertion failed");

`endif

@@ design/u8dec_pkg.sv @@
// Types, constants and helpers for the UTF-8 to UTF-16/UCS-4 decoder.
package u8dec_pkg;

  localparam int UnitW   = 21;
  localparam int MaxRes  = 4;
  localparam int HeldMax = 3;

  localparam logic [UnitW-1:0] REPL_CHAR = 21'h00FFFD;
  localparam logic [UnitW-1:0] SUPP_BASE = 21'h010000;
  localparam logic [UnitW-1:0] CODE_MAX  = 21'h10FFFF;
  localparam logic [UnitW-1:0] SURR_LO   = 21'h00D7FF;
  localparam logic [UnitW-1:0] SURR_END  = 21'h00E000;
  localparam logic [UnitW-1:0] BMP_MAX   = 21'h00FFFF;
  localparam logic [15:0]      HI_SURR   = 16'hD800;
  localparam logic [15:0]      LO_SURR   = 16'hDC00;

  // sequence length from a lead byte (0 = not a lead)
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             rep;
  } res_t;

  // one step's outcome: results plus how the held bytes change
  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [2:0]        cnt;
    logic [1:0]        hold_count;
    logic              hold_wr;
    logic [1:0]        hold_idx;
  } step_t;

  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] len;
    if (c[7] == 1'b0)           len = LEN_1;
    else if (c[7:5] == 3'b110)  len = LEN_2;
    else if (c[7:4] == 4'b1110) len = LEN_3;
    else if (c[7:3] == 5'b11110) len = LEN_4;
    else                        len = LEN_BAD;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return c[7:6] == 2'b10;
  endfunction

endpackage

@@ design/u8dec_step.sv @@
// Per-byte decode: combines held bytes with the new byte into up to four results.
module u8dec_step (
  input  logic [7:0]       held0,
  input  logic [7:0]       held1,
  input  logic [7:0]       held2,
  input  logic [1:0]       held_count,
  input  logic [7:0]       byte_in,
  input  logic             last_in,
  input  logic             utf16,
  output u8dec_pkg::step_t step
);
  import u8dec_pkg::*;

  always_comb begin
    logic [2:0]       need_x;
    logic [2:0]       need_h;
    logic             fresh_bad;
    logic [2:0]       fresh_cnt;
    res_t             fresh_res;
    logic             fresh_hold;
    logic             ext_bad;
    logic             complete;
    logic [UnitW-1:0] u;
    logic [UnitW-1:0] v;
    logic [2:0]       k;
    res_t             repl;

    repl.unit = REPL_CHAR;
    repl.rep  = 1'b1;
    need_x = seq_len(byte_in);
    need_h = seq_len(held0);
    k      = {1'b0, held_count};

    // new byte taken as a fresh lead
    fresh_bad  = (need_x == LEN_BAD) || ((need_x == LEN_2) && (byte_in[4:1] == 4'd0));
    fresh_hold = 1'b0;
    fresh_res  = repl;
    fresh_cnt  = 3'd1;
    if (!fresh_bad) begin
      if (need_x == LEN_1) begin
        fresh_res.unit = {13'd0, byte_in};
        fresh_res.rep  = 1'b0;
      end else if (!last_in) begin
        fresh_hold = 1'b1;
        fresh_cnt  = 3'd0;
      end
    end

    // held prefix is known good, so only the new byte can break it
    ext_bad = !is_cont(byte_in) ||
              ((held_count == 2'd1) &&
               (((need_h == LEN_3) && (held0[3:0] == 4'h0) && !byte_in[5]) ||
                ((need_h == LEN_3) && (held0[3:0] == 4'hD) && byte_in[5]) ||
                ((need_h == LEN_4) && (held0[2:0] == 3'd0) && (byte_in[5:4] == 2'd0))));
    complete = (({1'b0, held_count} + 3'd1) == need_h);

    case (need_h)
      LEN_2:   u = {10'd0, held0[4:0], byte_in[5:0]};
      LEN_3:   u = {5'd0, held0[3:0], held1[5:0], byte_in[5:0]};
      LEN_4:   u = {held0[2:0], held1[5:0], held2[5:0], byte_in[5:0]};
      default: u = '0;
    endcase
    v = u - SUPP_BASE;

    step.res        = {MaxRes{repl}};
    step.cnt        = 3'd0;
    step.hold_count = 2'd0;
    step.hold_wr    = 1'b0;
    step.hold_idx   = 2'd0;

    if ((held_count == 2'd0) || ext_bad) begin
      // each held continuation byte fails as a lead, then the new byte starts over
      for (int i = 0; i < MaxRes; i++) begin
        if (i == int'(k)) step.res[i] = fresh_res;
      end
      step.cnt = k + fresh_cnt;
      if (fresh_hold) begin
        step.hold_wr    = 1'b1;
        step.hold_idx   = 2'd0;
        step.hold_count = 2'd1;
      end
    end else if (complete) begin
      step.cnt = 3'd1;
      if (!utf16 || (u <= SURR_LO) || ((u >= SURR_END) && (u <= BMP_MAX))) begin
        step.res[0].unit = u;
        step.res[0].rep  = 1'b0;
      end else if ((u >= SUPP_BASE) && (u <= CODE_MAX)) begin
        step.res[0].unit = {5'd0, HI_SURR | {6'd0, v[19:10]}};
        step.res[0].rep  = 1'b0;
        step.res[1].unit = {5'd0, LO_SURR | {6'd0, v[9:0]}};
        step.res[1].rep  = 1'b0;
        step.cnt         = 3'd2;
      end
    end else if (last_in) begin
      // truncated at end of text: lead and every continuation become FFFD
      step.cnt = {1'b0, held_count} + 3'd1;
    end else begin
      step.hold_wr    = 1'b1;
      step.hold_idx   = held_count;
      step.hold_count = held_count + 2'd1;
    end
  end

endmodule

@@ design/utf8_to_utf16_ucs4_decoder.sv @@
// Top level of the UTF-8 to UTF-16/UCS-4 decoder.
//
//  channel | signals                                     | dir
//  in      | in_valid, in_ready, byte_value, last_byte    | request in
//  out     | out_valid, out_ready, code_unit, replaced,   | request out
//          | run_end, text_end                            |
//  cfg     | cfg_write, cfg_data (output_utf16)           | write only
//
// A byte is taken into the input register, decoded combinationally against the
// held bytes and its 0..4 results loaded into the result group register.
// Results leave one per cycle while out_ready is high; one byte per cycle
// when each gives at most one result and out_ready stays high.
// Bytes with no result pass without waiting on the output. Reset clears the
// held count, both valid flags and sets UTF-16 mode; no clearing pass.
module utf8_to_utf16_ucs4_decoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                byte_value,
  input  logic                      last_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [u8dec_pkg::UnitW-1:0] code_unit,
  output logic                      replaced,
  output logic                      run_end,
  output logic                      text_end,
  input  logic                      cfg_write,
  input  logic [0:0]                cfg_data
);
  import u8dec_pkg::*;

  `include "utf8_to_utf16_ucs4_decoder_defines.svh"

  logic             output_utf16;
  logic             item_valid;
  logic [7:0]       item_byte;
  logic             item_last;
  logic [7:0]       held_bytes [HeldMax];
  logic [1:0]       held_count;
  res_t [MaxRes-1:0] grp_res;
  logic [2:0]       grp_cnt;
  logic [1:0]       grp_ptr;
  logic             grp_valid;
  logic             grp_last;
  step_t            step;
  logic             grp_free;
  logic             fire;
  logic             load;
  res_t             cur;

  u8dec_step u_step (
    .held0      (held_bytes[0]),
    .held1      (held_bytes[1]),
    .held2      (held_bytes[2]),
    .held_count (held_count),
    .byte_in    (item_byte),
    .last_in    (item_last),
    .utf16      (output_utf16),
    .step       (step)
  );

  assign cur       = grp_res[grp_ptr];
  assign out_valid = grp_valid;
  assign code_unit = cur.unit;
  assign replaced  = cur.rep;
  assign run_end   = ({1'b0, grp_ptr} == (grp_cnt - 3'd1));
  assign text_end  = run_end && grp_last;

  assign grp_free = !grp_valid || (out_ready && run_end);
  assign fire     = item_valid && ((step.cnt == 3'd0) || grp_free);
  assign load     = fire && (step.cnt != 3'd0);
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_utf16 <= 1'b1;
    end else if (cfg_write) begin
      output_utf16 <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_byte <= byte_value;
      item_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (fire) begin
      held_count <= step.hold_count;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step.hold_wr) begin
      held_bytes[step.hold_idx] <= item_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      grp_ptr   <= 2'd0;
    end else if (load) begin
      grp_valid <= 1'b1;
      grp_ptr   <= 2'd0;
    end else if (grp_valid && out_ready) begin
      if (run_end) begin
        grp_valid <= 1'b0;
      end else begin
        grp_ptr <= grp_ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_res  <= step.res;
      grp_cnt  <= step.cnt;
      grp_last <= item_last;
    end
  end

  `U8DEC_ASSERT_NOW(a_grp_cnt_range, clk, rst, grp_valid,
                    (grp_cnt != 3'd0) && (grp_cnt <= 3'd4))
  `U8DEC_ASSERT_NOW(a_held_is_lead, clk, rst, held_count != 2'd0,
                    held_bytes[0][7:6] == 2'b11)
  `U8DEC_ASSERT_NEXT(a_last_flushes, clk, rst, fire && item_last, held_count == 2'd0)
  `U8DEC_ASSERT_NEXT(a_load_starts, clk, rst, load, grp_valid && (grp_ptr == 2'd0))
  `U8DEC_ASSERT_NEXT(a_group_continues, clk, rst, grp_valid && out_ready && !run_end,
                     grp_valid)

endmodule

@@ sim/u8dec_unit_checker.sv @@
// Checker for the UTF-8 decoder: predicts each result from the accepted bytes and compares.
module u8dec_unit_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [7:0]                  byte_value,
  input  logic                        last_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [u8dec_pkg::UnitW-1:0] code_unit,
  input  logic                        replaced,
  input  logic                        run_end,
  input  logic                        text_end,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_data,
  output int                          errors,
  output int                          pending
);
  import u8dec_pkg::*;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             rep;
    logic             last_of_byte;
    logic             last_of_text;
  } decoded_t;

  logic [7:0] held [HeldMax];
  int         held_n;
  logic       utf16_mode;
  logic [7:0] win [4];
  decoded_t   step_out [MaxRes];
  int         step_n;
  decoded_t   expected_units [$];

  function automatic int lead_len(input logic [7:0] c);
    if (!c[7]) return 1;
    if (c[7:5] == 3'b110) return 2;
    if (c[7:4] == 4'b1110) return 3;
    if (c[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  // true once the bytes in the window already rule the sequence out
  function automatic logic seq_broken(input int pos, input int need, input int avail);
    int have;
    have = (avail < need) ? avail : need;
    if (need == 0) return 1'b1;
    if (need == 2 && win[pos][4:1] == 4'd0) return 1'b1;
    for (int i = 1; i < have; i++)
      if (win[pos+i][7:6] != 2'b10) return 1'b1;
    if (have >= 2) begin
      // overlong 3-byte, encoded surrogate, overlong 4-byte
      if (need == 3 && win[pos][3:0] == 4'h0 && !win[pos+1][5]) return 1'b1;
      if (need == 3 && win[pos][3:0] == 4'hD && win[pos+1][5]) return 1'b1;
      if (need == 4 && win[pos][2:0] == 3'd0 && win[pos+1][5:4] == 2'b00) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic put_unit(input logic [UnitW-1:0] u, input logic r);
    if (step_n < MaxRes) begin
      step_out[step_n] = '{u, r, 1'b0, 1'b0};
      step_n++;
    end
  endtask

  task automatic emit_point(input logic [UnitW-1:0] u, input logic r);
    logic [UnitW-1:0] v;
    v = u - SUPP_BASE;
    if (!utf16_mode)
      put_unit(u, r);
    else if (u <= SURR_LO || (u >= SURR_END && u <= BMP_MAX))
      put_unit(u, r);
    else if (u >= SUPP_BASE && u <= CODE_MAX) begin
      put_unit({5'd0, HI_SURR | {6'd0, v[19:10]}}, r);
      put_unit({5'd0, LO_SURR | {6'd0, v[9:0]}}, r);
    end else
      put_unit(REPL_CHAR, 1'b1);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    int n, pos, avail, need;
    logic [UnitW-1:0] cp;
    n = held_n;
    for (int i = 0; i < n; i++) win[i] = held[i];
    win[n] = b;
    n++;
    held_n = 0;
    step_n = 0;
    pos = 0;
    while (pos < n) begin
      avail = n - pos;
      need = lead_len(win[pos]);
      if (seq_broken(pos, need, avail) || (avail < need && fin)) begin
        // only the lead is consumed, the rest is decoded again
        emit_point(REPL_CHAR, 1'b1);
        pos++;
      end else if (avail < need) begin
        for (int i = 0; i < avail; i++) held[i] = win[pos+i];
        held_n = avail;
        pos = n;
      end else begin
        case (need)
          1: cp = {13'd0, win[pos]};
          2: cp = {10'd0, win[pos][4:0], win[pos+1][5:0]};
          3: cp = {5'd0, win[pos][3:0], win[pos+1][5:0], win[pos+2][5:0]};
          default: cp = {win[pos][2:0], win[pos+1][5:0], win[pos+2][5:0], win[pos+3][5:0]};
        endcase
        emit_point(cp, 1'b0);
        pos += need;
      end
    end
    if (step_n > 0) begin
      step_out[step_n-1].last_of_byte = 1'b1;
      step_out[step_n-1].last_of_text = fin;
    end
    for (int i = 0; i < step_n; i++) expected_units.push_back(step_out[i]);
  endtask

  always @(posedge clk) begin
    decoded_t got, want;
    if (rst) begin
      held_n = 0;
      utf16_mode = 1'b1;
      expected_units.delete();
      errors = 0;
    end else begin
      if (cfg_write) utf16_mode = cfg_data[0];
      // a request is taken when valid and ready meet at the edge
      if (in_valid && in_ready) decode_byte(byte_value, last_byte);
      if (out_valid && out_ready) begin
        got = '{code_unit, replaced, run_end, text_end};
        if (expected_units.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h/%b/%b/%b",
                   $time, got.unit, got.rep, got.last_of_byte, got.last_of_text);
        end else begin
          want = expected_units.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch, expected %h/%b/%b/%b, actual %h/%b/%b/%b",
                     $time, want.unit, want.rep, want.last_of_byte, want.last_of_text,
                     got.unit, got.rep, got.last_of_byte, got.last_of_text);
          end
        end
      end
    end
    pending = expected_units.size();
  end

endmodule

@@ sim/utf8_to_utf16_ucs4_decoder_test.sv @@
// Testbench top for the UTF-8 decoder: drives bytes, mode writes and output stalls.
module utf8_to_utf16_ucs4_decoder_test;

  localparam int RX_OPEN = 0;
  localparam int RX_COIN = 1;
  localparam int RX_SLOW = 2;
  localparam int RX_BEAT = 3;
  localparam int RX_HOLD = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] byte_value = 8'd0;
  logic last_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [u8dec_pkg::UnitW-1:0] code_unit;
  logic replaced;
  logic run_end;
  logic text_end;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_data = 1'b0;

  int errors;
  int pending;
  int bytes_sent = 0;
  int burst_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  utf8_to_utf16_ucs4_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_unit  (code_unit),
    .replaced   (replaced),
    .run_end    (run_end),
    .text_end   (text_end),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data)
  );

  u8dec_unit_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_unit  (code_unit),
    .replaced   (replaced),
    .run_end    (run_end),
    .text_end   (text_end),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  function automatic logic [7:0] rand_cont();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    byte_value <= b;
    last_byte <= fin;
    do begin
      @(posedge clk);
    end while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // bytes are right-aligned, first byte sent from the top
  task automatic push_text(input logic [31:0] text, input int cnt, input logic fin);
    for (int k = cnt - 1; k >= 0; k--) push_byte(text[8*k +: 8], fin && k == 0);
  endtask

  task automatic set_mode(input logic m);
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // drain: wait until nothing is expected, then idle so a byte with no result can pass
  task automatic end_phase;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // mostly well-formed characters, some cut short or overlong, some raw noise
  task automatic send_random_char;
    logic [7:0] seq [$];
    logic [7:0] lead;
    logic fin;
    int kind, len, conts;
    kind = $urandom_range(0, 99);
    fin = ($urandom_range(0, 11) == 0);
    if (kind < 25) begin
      seq.push_back(8'($urandom_range(0, 127)));
    end else if (kind < 40) begin
      seq.push_back(8'($urandom_range(8'hC2, 8'hDF)));
      seq.push_back(rand_cont());
    end else if (kind < 60) begin
      lead = 8'($urandom_range(8'hE0, 8'hEF));
      seq.push_back(lead);
      if (lead == 8'hE0) seq.push_back(8'($urandom_range(8'hA0, 8'hBF)));
      else if (lead == 8'hED) seq.push_back(8'($urandom_range(8'h80, 8'h9F)));
      else seq.push_back(rand_cont());
      seq.push_back(rand_cont());
    end else if (kind < 80) begin
      lead = 8'($urandom_range(8'hF0, 8'hF7));
      seq.push_back(lead);
      if (lead == 8'hF0) seq.push_back(8'($urandom_range(8'h90, 8'hBF)));
      else seq.push_back(rand_cont());
      seq.push_back(rand_cont());
      seq.push_back(rand_cont());
    end else if (kind < 94) begin
      lead = 8'($urandom_range(8'hC0, 8'hF7));
      len = (lead < 8'hE0) ? 2 : (lead < 8'hF0) ? 3 : 4;
      conts = $urandom_range(0, len - 1);
      seq.push_back(lead);
      repeat (conts) seq.push_back(rand_cont());
    end else begin
      seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[i]) push_byte(seq[i], fin && i == seq.size() - 1);
  endtask

  initial begin : rx_pattern
    int style, span, tick;
    logic squeezed;
    squeezed = 1'b0;
    tick = 0;
    forever begin
      style = $urandom_range(RX_OPEN, RX_BEAT);
      span = $urandom_range(16, 96);
      if (!squeezed && bytes_sent >= 100) begin
        // long hold-off while the sender keeps going, so the input backs up
        squeezed = 1'b1;
        style = RX_HOLD;
        span = 300;
      end else if ($urandom_range(0, 24) == 0) begin
        style = RX_HOLD;
        span = $urandom_range(40, 120);
      end
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (style)
          RX_OPEN: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          RX_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
          RX_BEAT: out_ready <= (tick % 5 != 0);
          default: out_ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    int sent0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_mode(1'b1);
    push_text(32'h00, 1, 1'b0);
    push_text(32'hC280, 2, 1'b0);
    push_text(32'hEFBFBF, 3, 1'b0);
    push_text(32'hF4908080, 4, 1'b0);   // above the Unicode range
    push_text(32'h80, 1, 1'b0);
    push_text(32'hFF, 1, 1'b0);
    push_text(32'hC1, 1, 1'b0);
    push_text(32'hE080, 2, 1'b0);       // overlong
    push_text(32'hEDA0, 2, 1'b0);       // encoded surrogate
    push_text(32'hC241, 2, 1'b1);       // bad continuation
    end_phase;

    set_mode(1'b0);
    push_text(32'hF7BFBFBF, 4, 1'b0);
    push_text(32'hF09F, 2, 1'b0);       // left held across the mode change
    end_phase;

    set_mode(1'b1);
    push_text(32'h9880, 2, 1'b0);
    push_text(32'hE282, 2, 1'b1);       // cut short at end of text
    end_phase;

    for (int ph = 0; ph < 6; ph++) begin
      set_mode((ph < 2) ? ph[0] : 1'($urandom_range(0, 1)));
      sent0 = bytes_sent;
      while (bytes_sent - sent0 < 64) send_random_char;
      end_phase;
    end

    if (errors == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/u8dec_pkg.sv
design/u8dec_step.sv
design/utf8_to_utf16_ucs4_decoder.sv
sim/u8dec_unit_checker.sv
sim/utf8_to_utf16_ucs4_decoder_test.sv
